@@ sv/scalar_kalman_filter_assert.svh @@
// Assertion macros for the scalar Kalman filter.
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SKA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SKA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ska_pkg.sv @@
// Shared types and constants for the scalar Kalman filter.
`timescale 1ns / 1ps
package ska_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE = 1'b0,
		REG_MEASURE_NOISE = 1'b1
	} ska_reg_t;

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd66;
	localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN,
		ST_CALC,
		ST_OUT
	} ska_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic first;
	} ska_ctrl_t;

endpackage

@@ sv/ska_div.sv @@
// Bit-serial restoring divider giving the gain one quotient bit per cycle, MSB first.
`timescale 1ns / 1ps
module ska_div
	import ska_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ska_ctrl_t         ctrl,
	input  logic [DATA_W-1:0] pred,
	input  logic [DATA_W-1:0] mnoise,
	output logic              q_s1,
	output logic              q_vld_s1
);

	logic [DATA_W+1:0] rem_q;
	logic [DATA_W:0]   div_q;
	logic              zero_q;
	logic [DATA_W+1:0] trial;
	logic              ge;

	always_comb begin
		trial = ctrl.first ? rem_q : {rem_q[DATA_W:0], 1'b0};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q  <= {2'b00, pred};
			div_q  <= {1'b0, pred} + {1'b0, mnoise};
			zero_q <= (pred == '0) && (mnoise == '0);
		end else if (ctrl.step) begin
			rem_q <= ge ? (trial - {1'b0, div_q}) : trial;
		end
		q_s1 <= ge && !zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld_s1 <= 1'b0;
		end else begin
			q_vld_s1 <= ctrl.step;
		end
	end

endmodule

@@ sv/ska_mac.sv @@
// Serial MSB-first multipliers: gain * delta and gain * predicted variance.
`timescale 1ns / 1ps
module ska_mac
	import ska_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                         clk,
	input  ska_ctrl_t                    ctrl,
	input  logic                         q_bit,
	input  logic signed [DATA_W:0]       delta,
	input  logic        [DATA_W-1:0]     pred,
	output logic signed [FRAC_BITS+33:0] acc_d,
	output logic        [FRAC_BITS+32:0] acc_v
);

	localparam int unsigned PD_W = FRAC_BITS + 34;
	localparam int unsigned PV_W = FRAC_BITS + 33;

	logic signed [DATA_W:0]   delta_q;
	logic        [DATA_W-1:0] pred_q;
	logic signed [PD_W-1:0]   acc_d_q;
	logic        [PV_W-1:0]   acc_v_q;
	logic signed [PD_W-1:0]   add_d;
	logic        [PV_W-1:0]   add_v;

	always_comb begin
		add_d = q_bit ? {{(PD_W-DATA_W-1){delta_q[DATA_W]}}, delta_q} : '0;
		add_v = q_bit ? {{(PV_W-DATA_W){1'b0}}, pred_q} : '0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			delta_q <= delta;
			pred_q  <= pred;
			acc_d_q <= '0;
			acc_v_q <= '0;
		end else if (ctrl.step) begin
			acc_d_q <= {acc_d_q[PD_W-2:0], 1'b0} + add_d;
			acc_v_q <= {acc_v_q[PV_W-2:0], 1'b0} + add_v;
		end
	end

	assign acc_d = acc_d_q;
	assign acc_v = acc_v_q;

endmodule

@@ sv/scalar_kalman_filter.sv @@
// Top level of the one-dimensional Kalman filter with a bit-serial gain datapath.
// Gain bits come from the bit-serial divider, one gain bit per cycle, and feed the serial multipliers.
// Input is taken again once the result sits in the output register.
// Reset clears estimate, variance and control; noise registers return to 66 and 65536.
`timescale 1ns / 1ps
`include "scalar_kalman_filter_assert.svh"
module scalar_kalman_filter
	import ska_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] measurement
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic signed [DATA_W-1:0] m_tdata,   // [31:0] estimate
	input  logic                     cfg_wen,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_wdata
);

	localparam int unsigned PD_W  = FRAC_BITS + 34;
	localparam int unsigned PV_W  = FRAC_BITS + 33;
	localparam int unsigned CNT_W = $clog2(FRAC_BITS + 3);
	localparam logic [CNT_W-1:0] LAST_DIV = CNT_W'(FRAC_BITS);
	localparam logic [CNT_W-1:0] LAST_RUN = CNT_W'(FRAC_BITS + 1);
	localparam logic [PV_W-1:0]  ROUND_UP = PV_W'((64'd1 << FRAC_BITS) - 64'd1);

	ska_state_t state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;

	logic [DATA_W-1:0]        pn_q, mn_q;
	logic signed [DATA_W-1:0] est_q;
	logic [DATA_W-1:0]        var_q;
	logic signed [DATA_W-1:0] meas_q;
	logic [DATA_W-1:0]        pred_q;
	logic [DATA_W:0]          vpart_q;
	logic signed [DATA_W-1:0] out_q;
	logic                     m_tvalid_q;

	ska_ctrl_t div_ctrl, mac_ctrl;
	logic q_s1, q_vld_s1;
	logic signed [PD_W-1:0] acc_d;
	logic        [PV_W-1:0] acc_v;

	logic [DATA_W:0]          pred_sum;
	logic [DATA_W-1:0]        pred_sat;
	logic signed [DATA_W:0]   delta;
	logic signed [PD_W-1:0]   scaled;
	logic signed [DATA_W+2:0] upd;
	logic signed [DATA_W-1:0] upd_sat;
	logic [PV_W-1:0]          vsum;
	logic                     in_acc, out_free;

	always_comb begin
		pred_sum = {1'b0, var_q} + {1'b0, pn_q};
		pred_sat = pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
		delta    = {meas_q[DATA_W-1], meas_q} - {est_q[DATA_W-1], est_q};
		scaled   = acc_d >>> FRAC_BITS;
		upd      = {{3{est_q[DATA_W-1]}}, est_q} + scaled[DATA_W+2:0];
		if (upd[DATA_W+2:DATA_W-1] == '0 || upd[DATA_W+2:DATA_W-1] == '1) begin
			upd_sat = upd[DATA_W-1:0];
		end else if (upd[DATA_W+2]) begin
			upd_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			upd_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
		vsum     = acc_v + ROUND_UP;
		in_acc   = s_tvalid && s_tready;
		out_free = !m_tvalid_q || m_tready;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_PREP;
			ST_PREP: state_nxt = ST_RUN;
			ST_RUN:  if (cnt_q == LAST_RUN) state_nxt = ST_CALC;
			ST_CALC: state_nxt = ST_OUT;
			ST_OUT:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		div_ctrl = '0;
		mac_ctrl = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_PREP: begin
				div_ctrl.load = 1'b1;
				mac_ctrl.load = 1'b1;
			end
			ST_RUN: begin
				div_ctrl.step  = cnt_q <= LAST_DIV;
				div_ctrl.first = cnt_q == '0;
				mac_ctrl.step  = q_vld_s1;
			end
			ST_CALC, ST_OUT: ;
			default: ;
		endcase
	end

	ska_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.pred     (pred_q),
		.mnoise   (mn_q),
		.q_s1     (q_s1),
		.q_vld_s1 (q_vld_s1)
	);

	ska_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.q_bit (q_s1),
		.delta (delta),
		.pred  (pred_q),
		.acc_d (acc_d),
		.acc_v (acc_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pn_q       <= PROCESS_NOISE_RST;
			mn_q       <= MEASURE_NOISE_RST;
			est_q      <= '0;
			var_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= (state_q == ST_RUN) ? cnt_q + 1'b1 : '0;
			if (cfg_wen) begin
				unique case (ska_reg_t'(cfg_index))
					REG_PROCESS_NOISE: pn_q <= cfg_wdata;
					REG_MEASURE_NOISE: mn_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_CALC) begin
				est_q <= upd_sat;
			end
			if (state_q == ST_OUT && out_free) begin
				var_q      <= pred_q - vpart_q[DATA_W-1:0];
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			meas_q <= s_tdata;
			pred_q <= pred_sat;
		end
		if (state_q == ST_CALC) begin
			vpart_q <= vsum[FRAC_BITS +: DATA_W+1];
		end
		if (state_q == ST_OUT && out_free) begin
			out_q <= est_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	`SKA_ASSERT_NEXT(a_accept_prep, in_acc, state_q == ST_PREP, "accept did not start prep")
	`SKA_ASSERT_NEXT(a_out_load, state_q == ST_OUT && out_free,
		m_tvalid && m_tdata == $past(est_q), "result not loaded into output register")
	`SKA_ASSERT_NOW(a_var_bound, state_q == ST_OUT, vpart_q <= {1'b0, pred_q},
		"variance reduction exceeds prediction")
	`SKA_ASSERT_NOW(a_mac_in_run, q_vld_s1, state_q == ST_RUN, "gain bit outside run")

endmodule

@@ tb/scalar_kalman_filter_tb.sv @@
// Self-checking testbench for the scalar Kalman filter against an in-bench predictor.
`timescale 1ns / 1ps
module scalar_kalman_filter_tb;
	import ska_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = FRAC_BITS + 10;
	localparam longint EST_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint EST_MIN = -EST_MAX - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic signed [DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic signed [DATA_W-1:0] m_tdata;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_wdata = '0;

	// filter state and noise settings as the block should hold them
	logic [DATA_W-1:0] est_q;
	logic [DATA_W-1:0] var_q;
	logic [DATA_W-1:0] process_noise_q;
	logic [DATA_W-1:0] measure_noise_q;

	logic [DATA_W-1:0] expected_estimates[$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	scalar_kalman_filter #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // [31:0] measurement
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),   // [31:0] estimate
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// one filter step: predict variance, gain, move estimate, shrink variance
	function automatic logic [DATA_W-1:0] kalman_update(input logic [DATA_W-1:0] meas);
		bit [63:0] pred;
		bit [63:0] divisor;
		bit [63:0] gain;
		bit [63:0] var_next;
		longint meas_s;
		longint est_s;
		longint delta;
		longint upd;
		pred = 64'(var_q) + 64'(process_noise_q);
		if (pred > 64'hFFFF_FFFF)
			pred = 64'hFFFF_FFFF;
		divisor = pred + 64'(measure_noise_q);
		gain = (divisor != 0) ? (pred << FRAC_BITS) / divisor : 64'd0;
		meas_s = $signed(meas);
		est_s = $signed(est_q);
		delta = meas_s - est_s;
		upd = est_s + (($signed(gain) * delta) >>> FRAC_BITS);
		if (upd > EST_MAX)
			upd = EST_MAX;
		if (upd < EST_MIN)
			upd = EST_MIN;
		var_next = (((64'd1 << FRAC_BITS) - gain) * pred) >> FRAC_BITS;
		est_q = upd[DATA_W-1:0];
		var_q = var_next[DATA_W-1:0];
		return est_q;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_estimates.size() == 0) begin
				report_mismatch($sformatf("estimate %h with none pending", m_tdata));
			end else if (m_tdata !== expected_estimates[0]) begin
				report_mismatch($sformatf("estimate got %h exp %h",
					m_tdata, expected_estimates[0]));
				void'(expected_estimates.pop_front());
			end else begin
				void'(expected_estimates.pop_front());
			end
		end
	end

	// output ready: long hold-off when requested, otherwise random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_measurement(input logic [DATA_W-1:0] meas);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= meas;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_estimates.push_back(kalman_update(meas));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_estimates.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_noise(input ska_reg_t idx, input logic [DATA_W-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_PROCESS_NOISE)
			process_noise_q = val;
		else
			measure_noise_q = val;
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_noise();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 255);
			3: return $urandom_range(0, 32'h0004_0000);
			4: return $urandom_range(0, 32'h0100_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_measurement();
		case ($urandom_range(9))
			0: return est_q + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return est_q;
			default: return $urandom();
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_measurement(32'h0000_0000);
		send_measurement(32'h7FFF_FFFF);
		send_measurement(32'h8000_0000);
		send_measurement(32'hFFFF_FFFF);
		send_measurement(32'h0001_0000);
		send_measurement(32'h7FFF_FFFF);
		wait_drained();
	endtask

	task automatic test_zero_measure_noise();
		write_noise(REG_MEASURE_NOISE, '0);
		write_noise(REG_PROCESS_NOISE, 32'd1);
		send_measurement(32'h8000_0000);
		send_measurement(32'h7FFF_FFFF);
		send_measurement(32'h1234_5678);
		wait_drained();
	endtask

	// variance is now zero; with both noises zero the divisor is zero
	task automatic test_zero_divisor();
		write_noise(REG_PROCESS_NOISE, '0);
		send_measurement(32'h7FFF_FFFF);
		send_measurement(32'h8000_0000);
		send_measurement(32'h0000_0000);
		wait_drained();
	endtask

	task automatic test_variance_saturation();
		write_noise(REG_PROCESS_NOISE, '1);
		write_noise(REG_MEASURE_NOISE, '1);
		send_measurement(32'h7FFF_FFFF);
		send_measurement(32'h8000_0000);
		send_measurement(32'h5555_AAAA);
		send_measurement(32'hAAAA_5555);
		wait_drained();
	endtask

	task automatic test_estimate_limits();
		write_noise(REG_MEASURE_NOISE, 32'd1);
		send_measurement(32'h7FFF_FFFF);
		send_measurement(32'h8000_0000);
		send_measurement(32'h7FFF_FFFF);
		wait_drained();
	endtask

	task automatic test_backpressure();
		write_noise(REG_PROCESS_NOISE, PROCESS_NOISE_RST);
		write_noise(REG_MEASURE_NOISE, MEASURE_NOISE_RST);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left <= 300;
		repeat (12) send_measurement($urandom());
		wait_drained();
	endtask

	task automatic test_drain_pause();
		repeat (5) send_measurement(pick_measurement());
		wait_drained();
		repeat (5) send_measurement(pick_measurement());
		wait_drained();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int seg = 0; seg < 4; seg++) begin
			write_noise(REG_PROCESS_NOISE, pick_noise());
			write_noise(REG_MEASURE_NOISE, pick_noise());
			repeat (n / 4) send_measurement(pick_measurement());
			wait_drained();
		end
	endtask

	initial begin
		process_noise_q = PROCESS_NOISE_RST;
		measure_noise_q = MEASURE_NOISE_RST;
		est_q = '0;
		var_q = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_measure_noise();
		test_zero_divisor();
		test_variance_saturation();
		test_estimate_limits();
		test_backpressure();
		test_drain_pause();
		test_random_traffic(0, 0, 400);
		test_random_traffic(58, 0, 400);
		test_random_traffic(0, 58, 400);
		test_random_traffic(19, 19, 400);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_estimates.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
